/* design/jfe_pkg.sv */
`timescale 1ns / 1ps

package jfe_pkg;

  // Frame store geometry: two halves of BUF_DEPTH bytes each
  localparam int BUF_DEPTH = 262144;
  localparam int BUF_AW    = $clog2(BUF_DEPTH);
  localparam int MEM_DEPTH = 2 * BUF_DEPTH;

  // Field widths
  localparam int LEN_W  = 19;
  localparam int ADDR_W = 18;

  // Queue geometry, shared by the command and result queues
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // Marker bytes
  localparam logic [7:0] MARK_PREFIX = 8'hFF;
  localparam logic [7:0] MARK_SOI    = 8'hD8;
  localparam logic [7:0] MARK_EOI    = 8'hD9;

  // Limit register reset value (also the upper clamp) and lower clamp
  localparam logic [LEN_W-1:0] LIMIT_RESET = LEN_W'(BUF_DEPTH);
  localparam logic [LEN_W-1:0] LIMIT_MIN   = LEN_W'(2);

  // Command codes
  localparam logic [1:0] CMD_STREAM  = 2'd0;
  localparam logic [1:0] CMD_READ    = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;
  localparam logic [1:0] CMD_RESYNC  = 2'd3;

  // Read data source codes
  localparam logic [1:0] RD_ZERO = 2'd0;
  localparam logic [1:0] RD_FF   = 2'd1;
  localparam logic [1:0] RD_SOI  = 2'd2;
  localparam logic [1:0] RD_MEM  = 2'd3;

  // Classified command, as held in the command queue
  typedef struct packed {
    logic [1:0]        cmd;
    logic [7:0]        data_byte;
    logic [ADDR_W-1:0] read_address;
    logic              byte_ff;
    logic              byte_soi;
    logic              byte_eoi;
    logic              addr_hdr0;
    logic              addr_hdr1;
  } item_t;

  // One result transaction
  typedef struct packed {
    logic [7:0]       read_data;
    logic             frame_done;
    logic [LEN_W-1:0] frame_length;
    logic             frame_dropped;
    logic             overflow;
    logic             frame_ready;
  } res_t;

endpackage

/* design/jfe_ram.sv */
`timescale 1ns / 1ps

// Generic single-address RAM, registered read
module jfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/jfe_front.sv */
`timescale 1ns / 1ps

// Front end: takes input transactions, decodes markers and header
// addresses, and holds them in a short command queue for the back end.
module jfe_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic [1:0]                 in_command,
  input  logic [7:0]                 in_data_byte,
  input  logic [jfe_pkg::ADDR_W-1:0] in_read_address,
  output logic                       q_valid,
  output jfe_pkg::item_t             q_item,
  input  logic                       q_pop
);

  jfe_pkg::item_t            qmem_r [jfe_pkg::QDEPTH];
  logic [jfe_pkg::QAW-1:0]   wp_r, wp_nxt;
  logic [jfe_pkg::QAW-1:0]   rp_r, rp_nxt;
  logic [jfe_pkg::QCW-1:0]   cnt_r, cnt_nxt;
  jfe_pkg::item_t            cls;
  logic                      wr, rd;

  // Classification of the incoming transaction
  always_comb begin
    cls.cmd          = in_command;
    cls.data_byte    = in_data_byte;
    cls.read_address = in_read_address;
    cls.byte_ff      = (in_data_byte == jfe_pkg::MARK_PREFIX);
    cls.byte_soi     = (in_data_byte == jfe_pkg::MARK_SOI);
    cls.byte_eoi     = (in_data_byte == jfe_pkg::MARK_EOI);
    cls.addr_hdr0    = (in_read_address == jfe_pkg::ADDR_W'(0));
    cls.addr_hdr1    = (in_read_address == jfe_pkg::ADDR_W'(1));
  end

  assign full    = (cnt_r == jfe_pkg::QCW'(jfe_pkg::QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_item  = qmem_r[rp_r];
  assign wr      = push && !full;
  assign rd      = q_pop && q_valid;

  // Queue pointers
  always_comb begin
    wp_nxt  = wr ? wp_r + 1'b1 : wp_r;
    rp_nxt  = rd ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + jfe_pkg::QCW'(wr) - jfe_pkg::QCW'(rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (wr) begin
      qmem_r[wp_r] <= cls;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (full && !rd) |=> (wp_r == $past(wp_r)))
    else $error("command queue written while full");

  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (wp_r == rp_r))
    else $error("command queue pointers differ while empty");

  assert property (@(posedge clk) disable iff (!rst_n)
    (wr && !rd) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("command queue count lost a transaction");

endmodule

/* design/jfe_back.sv */
`timescale 1ns / 1ps

// Back end: executes classified commands against the parser and frame
// state, drives the frame store, and queues the result transactions.
module jfe_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [jfe_pkg::LEN_W-1:0] cfg_wr_data,
  input  logic                      q_valid,
  input  jfe_pkg::item_t            q_item,
  output logic                      q_pop,
  output logic                      empty,
  input  logic                      pop,
  output jfe_pkg::res_t             out_res
);

  // Parser and frame state
  logic                      in_frame_r, in_frame_nxt;
  logic                      prev_ff_r, prev_ff_nxt;
  logic [jfe_pkg::LEN_W-1:0] wcnt_r, wcnt_nxt;
  logic                      half_r, half_nxt;
  logic [jfe_pkg::LEN_W-1:0] len_r, len_nxt;
  logic                      ready_r, ready_nxt;
  logic [jfe_pkg::LEN_W-1:0] limit_r, limit_nxt;

  // Result stage (aligned with the RAM read)
  logic                      rv_r, rv_nxt;
  jfe_pkg::res_t             rres_r, rres_nxt;
  logic [1:0]                rsel_r, rsel_nxt;

  // Result queue
  jfe_pkg::res_t             oq_r [jfe_pkg::QDEPTH];
  logic [jfe_pkg::QAW-1:0]   owp_r, owp_nxt;
  logic [jfe_pkg::QAW-1:0]   orp_r, orp_nxt;
  logic [jfe_pkg::QCW-1:0]   ocnt_r, ocnt_nxt;
  logic [jfe_pkg::QCW:0]     credit_use;
  jfe_pkg::res_t             push_res;
  logic                      opop;

  // Frame store port
  logic                      ram_we, ram_re;
  logic [jfe_pkg::BUF_AW:0]  ram_addr;
  logic [7:0]                ram_wdata, ram_rdata;

  logic                      go, ends;
  logic [jfe_pkg::LEN_W-1:0] wcnt_inc;

  // Clamp the byte limit when it is written
  always_comb begin
    limit_nxt = limit_r;
    if (cfg_wr_en) begin
      if (cfg_wr_data < jfe_pkg::LIMIT_MIN) begin
        limit_nxt = jfe_pkg::LIMIT_MIN;
      end else if (cfg_wr_data > jfe_pkg::LIMIT_RESET) begin
        limit_nxt = jfe_pkg::LIMIT_RESET;
      end else begin
        limit_nxt = cfg_wr_data;
      end
    end
  end

  // Issue only with a free result slot, counting the one in flight
  assign credit_use = (jfe_pkg::QCW+1)'(ocnt_r) + (jfe_pkg::QCW+1)'(rv_r);
  assign go         = q_valid && (credit_use < (jfe_pkg::QCW+1)'(jfe_pkg::QDEPTH));
  assign q_pop      = go;
  assign wcnt_inc   = wcnt_r + 1'b1;
  assign ends       = prev_ff_r && q_item.byte_eoi;

  // Command execution
  always_comb begin
    in_frame_nxt = in_frame_r;
    prev_ff_nxt  = prev_ff_r;
    wcnt_nxt     = wcnt_r;
    half_nxt     = half_r;
    len_nxt      = len_r;
    ready_nxt    = ready_r;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_addr     = {half_r, wcnt_r[jfe_pkg::BUF_AW-1:0]};
    ram_wdata    = q_item.data_byte;
    rsel_nxt     = jfe_pkg::RD_ZERO;
    rres_nxt     = '0;
    if (go) begin
      case (q_item.cmd)
        jfe_pkg::CMD_STREAM: begin
          prev_ff_nxt = q_item.byte_ff;
          if (!in_frame_r) begin
            // Header bytes are implied, not stored
            if (prev_ff_r && q_item.byte_soi) begin
              wcnt_nxt     = jfe_pkg::LEN_W'(2);
              in_frame_nxt = 1'b1;
            end
          end else if (wcnt_r >= limit_r) begin
            wcnt_nxt          = '0;
            in_frame_nxt      = 1'b0;
            rres_nxt.overflow = 1'b1;
          end else begin
            ram_we   = 1'b1;
            wcnt_nxt = wcnt_inc;
            if (ends) begin
              rres_nxt.frame_dropped = ready_r;
              rres_nxt.frame_done    = 1'b1;
              half_nxt               = !half_r;
              len_nxt                = wcnt_inc;
              ready_nxt              = 1'b1;
              wcnt_nxt               = '0;
              in_frame_nxt           = 1'b0;
            end
          end
        end
        jfe_pkg::CMD_READ: begin
          ram_re   = 1'b1;
          ram_addr = {!half_r, q_item.read_address[jfe_pkg::BUF_AW-1:0]};
          if (ready_r && ({1'b0, q_item.read_address} < len_r)) begin
            if (q_item.addr_hdr0) begin
              rsel_nxt = jfe_pkg::RD_FF;
            end else if (q_item.addr_hdr1) begin
              rsel_nxt = jfe_pkg::RD_SOI;
            end else begin
              rsel_nxt = jfe_pkg::RD_MEM;
            end
          end
        end
        jfe_pkg::CMD_RELEASE: begin
          ready_nxt = 1'b0;
        end
        jfe_pkg::CMD_RESYNC: begin
          in_frame_nxt = 1'b0;
          prev_ff_nxt  = 1'b0;
          wcnt_nxt     = '0;
          len_nxt      = '0;
          ready_nxt    = 1'b0;
        end
        default: begin
          ready_nxt = ready_r;
        end
      endcase
      rres_nxt.frame_length = len_nxt;
      rres_nxt.frame_ready  = ready_nxt;
    end
    rv_nxt = go;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      prev_ff_r  <= 1'b0;
      wcnt_r     <= '0;
      half_r     <= 1'b0;
      len_r      <= '0;
      ready_r    <= 1'b0;
      limit_r    <= jfe_pkg::LIMIT_RESET;
      rv_r       <= 1'b0;
    end else begin
      in_frame_r <= in_frame_nxt;
      prev_ff_r  <= prev_ff_nxt;
      wcnt_r     <= wcnt_nxt;
      half_r     <= half_nxt;
      len_r      <= len_nxt;
      ready_r    <= ready_nxt;
      limit_r    <= limit_nxt;
      rv_r       <= rv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rres_r <= rres_nxt;
    rsel_r <= rsel_nxt;
  end

  // Frame store, two halves
  jfe_ram #(
    .WIDTH (8),
    .DEPTH (jfe_pkg::MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Merge read data into the result
  always_comb begin
    push_res = rres_r;
    case (rsel_r)
      jfe_pkg::RD_FF:  push_res.read_data = jfe_pkg::MARK_PREFIX;
      jfe_pkg::RD_SOI: push_res.read_data = jfe_pkg::MARK_SOI;
      jfe_pkg::RD_MEM: push_res.read_data = ram_rdata;
      default:         push_res.read_data = 8'h00;
    endcase
  end

  // Result queue
  assign empty   = (ocnt_r == '0);
  assign out_res = oq_r[orp_r];
  assign opop    = pop && !empty;

  always_comb begin
    owp_nxt  = rv_r ? owp_r + 1'b1 : owp_r;
    orp_nxt  = opop ? orp_r + 1'b1 : orp_r;
    ocnt_nxt = ocnt_r + jfe_pkg::QCW'(rv_r) - jfe_pkg::QCW'(opop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= '0;
      orp_r  <= '0;
      ocnt_r <= '0;
    end else begin
      owp_r  <= owp_nxt;
      orp_r  <= orp_nxt;
      ocnt_r <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rv_r) begin
      oq_r[owp_r] <= push_res;
    end
  end

  // A lower limit written mid-frame may leave the count above it until the next byte
  assert property (@(posedge clk) disable iff (!rst_n)
    in_frame_r |-> ((wcnt_r >= jfe_pkg::LEN_W'(2)) && (wcnt_r <= jfe_pkg::LIMIT_RESET)))
    else $error("write count outside frame bounds");

  assert property (@(posedge clk) disable iff (!rst_n)
    credit_use <= (jfe_pkg::QCW+1)'(jfe_pkg::QDEPTH))
    else $error("result queue overcommitted");

  assert property (@(posedge clk) disable iff (!rst_n)
    (go && (q_item.cmd == jfe_pkg::CMD_STREAM) && in_frame_r && (wcnt_r < limit_r) && ends)
      |=> (half_r != $past(half_r)) && ready_r)
    else $error("completed frame did not swap halves");

  assert property (@(posedge clk) disable iff (!rst_n)
    ready_r |-> (len_r > jfe_pkg::LEN_W'(2)))
    else $error("held frame shorter than its markers");

endmodule

/* design/jpeg_frame_extractor.sv */
`timescale 1ns / 1ps

// Channel   Ports                                         Handshake
// input     in_command, in_data_byte, in_read_address     push / full
// result    out_read_data, out_frame_done, out_frame_length,
//           out_frame_dropped, out_overflow, out_frame_ready  empty / pop
// config    cfg_wr_data (byte limit)                      cfg_wr_en
//
// One transaction per cycle sustained while neither queue is held up; a result
// passes the command queue, execute with frame store read, and the result
// queue write before it shows on the result ports.
// Four-entry queues on both sides let either side stall independently.
// Synchronous active-low reset; the frame store is not cleared, bytes are
// only read back from frames that have been written.
module jpeg_frame_extractor (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic [1:0]                 in_command,
  input  logic [7:0]                 in_data_byte,
  input  logic [jfe_pkg::ADDR_W-1:0] in_read_address,
  output logic                       empty,
  input  logic                       pop,
  output logic [7:0]                 out_read_data,
  output logic                       out_frame_done,
  output logic [jfe_pkg::LEN_W-1:0]  out_frame_length,
  output logic                       out_frame_dropped,
  output logic                       out_overflow,
  output logic                       out_frame_ready,
  input  logic                       cfg_wr_en,
  input  logic [jfe_pkg::LEN_W-1:0]  cfg_wr_data
);

  logic           q_valid;
  logic           q_pop;
  jfe_pkg::item_t q_item;
  jfe_pkg::res_t  out_res;

  // Accept and classify
  jfe_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_command      (in_command),
    .in_data_byte    (in_data_byte),
    .in_read_address (in_read_address),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop)
  );

  // Execute and queue results
  jfe_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .empty       (empty),
    .pop         (pop),
    .out_res     (out_res)
  );

  assign out_read_data     = out_res.read_data;
  assign out_frame_done    = out_res.frame_done;
  assign out_frame_length  = out_res.frame_length;
  assign out_frame_dropped = out_res.frame_dropped;
  assign out_overflow      = out_res.overflow;
  assign out_frame_ready   = out_res.frame_ready;

endmodule
